// ===== design/dcsd_pkg.sv =====
package dcsd_pkg;

    // Opcodes of the command stream, and the marker for "no command open".
    localparam logic [3:0] OP_ACK         = 4'h0;
    localparam logic [3:0] OP_CURSOR      = 4'h1;
    localparam logic [3:0] OP_TEXT        = 4'h2;
    localparam logic [3:0] OP_PIXEL       = 4'h3;
    localparam logic [3:0] OP_FILL_RECT   = 4'h4;
    localparam logic [3:0] OP_DRAW_RECT   = 4'h5;
    localparam logic [3:0] OP_TEXT_COLOR  = 4'h6;
    localparam logic [3:0] OP_VRAM_WRITE  = 4'h7;
    localparam logic [3:0] OP_BITMAP      = 4'h8;
    localparam logic [3:0] OP_DISP_SELECT = 4'h9;
    localparam logic [3:0] OP_PAL_IMAGE   = 4'hA;
    localparam logic [3:0] OP_FILL_DISP   = 4'hB;
    localparam logic [3:0] OP_IDLE        = 4'hF;

    // Result kinds.
    localparam logic [3:0] KIND_ACK        = 4'd0;
    localparam logic [3:0] KIND_CURSOR     = 4'd1;
    localparam logic [3:0] KIND_TEXT_CHAR  = 4'd2;
    localparam logic [3:0] KIND_PIXEL      = 4'd3;
    localparam logic [3:0] KIND_FILL_RECT  = 4'd4;
    localparam logic [3:0] KIND_DRAW_RECT  = 4'd5;
    localparam logic [3:0] KIND_TEXT_COLOR = 4'd6;
    localparam logic [3:0] KIND_VRAM_WORD  = 4'd7;
    localparam logic [3:0] KIND_BITMAP     = 4'd8;
    localparam logic [3:0] KIND_PAL_IMAGE  = 4'd9;
    localparam logic [3:0] KIND_FILL_DISP  = 4'd10;

    localparam int unsigned SECTOR_WORDS = 256;
    localparam int unsigned FIELD_BYTES  = 10;
    localparam int unsigned RESULT_BYTES = 17;

    typedef logic [9:0] t_count;
    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] x_end;
        logic [15:0] y_end;
        logic [15:0] color;
        logic [16:0] vram_addr;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [7:0]  palette_len;
        logic [7:0]  text_char;
    } t_result;

    // Operand bytes that follow each opcode.
    function automatic t_count operand_count(input logic [3:0] op);
        t_count n;
        case (op)
            OP_CURSOR:      n = 10'd4;
            OP_TEXT:        n = 10'd1;
            OP_PIXEL:       n = 10'd6;
            OP_FILL_RECT:   n = 10'd10;
            OP_DRAW_RECT:   n = 10'd10;
            OP_TEXT_COLOR:  n = 10'd2;
            OP_VRAM_WRITE:  n = 10'd514;
            OP_BITMAP:      n = 10'd8;
            OP_DISP_SELECT: n = 10'd1;
            OP_PAL_IMAGE:   n = 10'd9;
            OP_FILL_DISP:   n = 10'd2;
            default:        n = 10'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== design/dcsd_parser.sv =====
module dcsd_parser #(
    parameter int unsigned VRAM_WORDS = 131072
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic [9:0]        i_vram_sectors,
    output logic              o_emit,
    output dcsd_pkg::t_result o_result
);
    import dcsd_pkg::*;

    localparam int unsigned SECTOR_CAP = VRAM_WORDS / SECTOR_WORDS;

    logic [3:0]  r_op,          n_op;
    t_count      r_left,        n_left;
    t_byte       r_field [FIELD_BYTES];
    t_byte       n_field [FIELD_BYTES];
    logic [7:0]  r_text_left,   n_text_left;
    logic [16:0] r_write_base,  n_write_base;
    logic [7:0]  r_word_count,  n_word_count;
    logic [7:0]  r_high_half,   n_high_half;
    logic        r_sector_valid, n_sector_valid;

    t_count      w_k;
    logic [15:0] w_sector;
    logic [16:0] w_limit;
    logic        w_sector_ok;
    logic [16:0] w_sector_addr;
    logic        w_emit;
    t_result     w_res;

    assign w_k = operand_count(r_op) - r_left;

    // Sector limit saturates to what the video memory can hold.
    assign w_limit = ({7'd0, i_vram_sectors} > 17'(SECTOR_CAP)) ? 17'(SECTOR_CAP)
                                                                 : {7'd0, i_vram_sectors};
    // The sector number is complete once its second byte is on the input.
    assign w_sector      = (w_k == 10'd1) ? {r_field[0], i_byte} : {r_field[0], r_field[1]};
    assign w_sector_ok   = {1'b0, w_sector} < w_limit;
    assign w_sector_addr = {w_sector[8:0], 8'd0};

    always_comb begin
        n_op           = r_op;
        n_left         = r_left;
        n_field        = r_field;
        n_text_left    = r_text_left;
        n_write_base   = r_write_base;
        n_word_count   = r_word_count;
        n_high_half    = r_high_half;
        n_sector_valid = r_sector_valid;
        w_emit         = 1'b0;
        w_res          = '0;

        if (r_op == OP_IDLE) begin
            if (i_byte == {4'd0, OP_ACK}) begin
                w_res.kind = KIND_ACK;
                w_emit     = 1'b1;
            end else if (i_byte inside {[8'h01:8'h0B]}) begin
                n_op         = i_byte[3:0];
                n_left       = operand_count(i_byte[3:0]);
                n_word_count = '0;
                n_high_half  = '0;
            end
        end else if (r_left != '0) begin
            if (w_k < t_count'(FIELD_BYTES)) begin
                n_field[w_k[3:0]] = i_byte;
            end
            n_left = r_left - 10'd1;

            if (r_op == OP_VRAM_WRITE) begin
                if (w_k == 10'd1) begin
                    n_sector_valid = w_sector_ok;
                    n_write_base   = w_sector_addr;
                    n_word_count   = '0;
                end else if (w_k >= 10'd2) begin
                    if (!w_k[0]) begin
                        n_high_half = i_byte;
                    end else begin
                        if (r_sector_valid) begin
                            w_res.kind      = KIND_VRAM_WORD;
                            w_res.color     = {r_high_half, i_byte};
                            w_res.vram_addr = r_write_base + {9'd0, r_word_count};
                            w_emit          = 1'b1;
                        end
                        n_word_count = r_word_count + 8'd1;
                    end
                end
            end

            if (r_left == 10'd1) begin
                n_op = OP_IDLE;
                case (r_op)
                    OP_CURSOR: begin
                        w_res.kind = KIND_CURSOR;
                        w_res.x    = {n_field[0], n_field[1]};
                        w_res.y    = {n_field[2], n_field[3]};
                        w_emit     = 1'b1;
                    end
                    OP_TEXT: begin
                        n_text_left = i_byte;
                        if (i_byte != '0) begin
                            n_op = OP_TEXT;
                        end
                    end
                    OP_PIXEL: begin
                        w_res.kind  = KIND_PIXEL;
                        w_res.x     = {n_field[0], n_field[1]};
                        w_res.y     = {n_field[2], n_field[3]};
                        w_res.color = {n_field[4], n_field[5]};
                        w_emit      = 1'b1;
                    end
                    OP_FILL_RECT, OP_DRAW_RECT: begin
                        w_res.kind  = (r_op == OP_FILL_RECT) ? KIND_FILL_RECT
                                                             : KIND_DRAW_RECT;
                        w_res.x     = {n_field[0], n_field[1]};
                        w_res.y     = {n_field[2], n_field[3]};
                        w_res.x_end = {n_field[4], n_field[5]};
                        w_res.y_end = {n_field[6], n_field[7]};
                        w_res.color = {n_field[8], n_field[9]};
                        w_emit      = 1'b1;
                    end
                    OP_TEXT_COLOR: begin
                        w_res.kind  = KIND_TEXT_COLOR;
                        w_res.color = {n_field[0], n_field[1]};
                        w_emit      = 1'b1;
                    end
                    OP_BITMAP, OP_PAL_IMAGE: begin
                        if (w_sector_ok) begin
                            w_res.kind      = (r_op == OP_BITMAP) ? KIND_BITMAP
                                                                  : KIND_PAL_IMAGE;
                            w_res.x         = {n_field[2], n_field[3]};
                            w_res.y         = {n_field[4], n_field[5]};
                            w_res.vram_addr = w_sector_addr;
                            w_res.width     = n_field[6];
                            w_res.height    = n_field[7];
                            if (r_op == OP_PAL_IMAGE) begin
                                w_res.palette_len = n_field[8];
                            end
                            w_emit = 1'b1;
                        end
                    end
                    OP_FILL_DISP: begin
                        w_res.kind  = KIND_FILL_DISP;
                        w_res.color = {n_field[0], n_field[1]};
                        w_emit      = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            // Character phase of a text command.
            if (r_text_left != '0) begin
                w_res.kind      = KIND_TEXT_CHAR;
                w_res.text_char = i_byte;
                w_emit          = 1'b1;
                n_text_left     = r_text_left - 8'd1;
            end
            if (n_text_left == '0) begin
                n_op = OP_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op           <= OP_IDLE;
            r_left         <= '0;
            r_text_left    <= '0;
            r_word_count   <= '0;
            r_high_half    <= '0;
            r_sector_valid <= 1'b0;
            r_write_base   <= '0;
        end else if (i_fire) begin
            r_op           <= n_op;
            r_left         <= n_left;
            r_text_left    <= n_text_left;
            r_word_count   <= n_word_count;
            r_high_half    <= n_high_half;
            r_sector_valid <= n_sector_valid;
            r_write_base   <= n_write_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_field <= n_field;
        end
    end

    assign o_emit   = i_fire && w_emit;
    assign o_result = w_res;

`ifndef SYNTHESIS
    a_idle_no_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op == OP_IDLE) |-> (r_left == '0))
        else $error("operand count left open with no command");

    a_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= operand_count(r_op))
        else $error("operand count exceeds command length");

    a_text_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_text_left != '0) |-> (r_op == OP_TEXT && r_left == '0))
        else $error("characters pending outside the text phase");

    a_vram_word_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.kind == KIND_VRAM_WORD) |-> r_sector_valid)
        else $error("video memory word sent for a rejected sector");
`endif

endmodule

// ===== design/display_command_stream_decoder.sv =====
// Channel   | Direction | Signals                         | Contents
// ----------+-----------+---------------------------------+-------------------------------
// s_axis    | in        | tvalid, tready, tdata[7:0]      | one byte of the command stream
// m_axis    | out       | tvalid, tready, tdata, tuser    | one decoded result
// cfg       | in        | i_cfg_we, i_cfg_wdata[9:0]      | vram_sectors register
//
// The block takes one byte per cycle unless the result register is full and not being taken.
// A byte is decoded while it sits in the input register, and its result is loaded into the
// result register when the decoder advances on it; from there it transfers downstream.
// The input register frees itself whenever the result register is empty or being taken,
// so the rate is set only by the downstream side. Reset (synchronous, active low) opens
// with no command in progress and vram_sectors at 512; no clearing pass is needed.
module display_command_stream_decoder #(
    parameter int unsigned VRAM_WORDS = 131072
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Byte stream in. tdata: data_byte[7:0].
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    // Results out.
    // tdata: x[15:0], y[31:16], x_end[47:32], y_end[63:48], color[79:64],
    //        vram_addr[96:80], width[104:97], height[112:105], palette_len[120:113],
    //        text_char[128:121], zero fill[135:129].
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,
    // tuser: kind[3:0].
    output logic [3:0]   m_axis_tuser,
    // Configuration write of vram_sectors.
    input  logic         i_cfg_we,
    input  logic [9:0]   i_cfg_wdata
);
    import dcsd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [9:0] r_vram_sectors;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_fire;
    logic       w_emit;
    t_result    w_result;

    // The decoder advances on the buffered byte whenever the result register can take
    // whatever that byte produces.
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vram_sectors <= 10'd512;
        end else if (i_cfg_we) begin
            r_vram_sectors <= i_cfg_wdata;
        end
    end

    dcsd_parser #(
        .VRAM_WORDS (VRAM_WORDS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_byte         (r_in_byte),
        .i_vram_sectors (r_vram_sectors),
        .o_emit         (w_emit),
        .o_result       (w_result)
    );

    // Result register: loads on a decoded result, empties when the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {7'd0, r_out.text_char, r_out.palette_len, r_out.height,
                            r_out.width, r_out.vram_addr, r_out.color, r_out.y_end,
                            r_out.x_end, r_out.y, r_out.x};

`ifndef SYNTHESIS
    a_result_from_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_fire))
        else $error("result register loaded without a decoded byte");

    a_no_byte_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid)
        else $error("buffered byte dropped before decode");
`endif

endmodule
